// File: hw/rtl/midipair_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the MIDI note pairing block.
package midipair_pkg;

  localparam int KEY_W     = 7;
  localparam int NUM_KEYS  = 128;
  localparam int TIME_W    = 32;
  localparam int CHAN_W    = 4;
  localparam int VEL_W     = 7;

  localparam int STACK_DEPTH_DEF = 4;
  localparam int QUEUE_DEPTH     = 4;

  // Event op codes.
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_NEW_TRK  = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_COMPLETE  = 2'd0;
  localparam logic [1:0] STAT_UNMATCHED = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // Command kinds handed from the front end to the back end.
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] event_time;
    logic [CHAN_W-1:0] channel;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  velocity;
  } evt_beat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [KEY_W-1:0]  note_key;
    logic [CHAN_W-1:0] note_channel;
    logic [VEL_W-1:0]  note_velocity;
  } note_beat_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TIME_W-1:0] event_time;
    logic [CHAN_W-1:0] channel;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  velocity;
  } cmd_t;

  // One pending note-on as held in the stack memory.
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [CHAN_W-1:0] channel;
    logic [VEL_W-1:0]  velocity;
  } pend_t;

endpackage

// File: hw/rtl/midipair_front.sv
`timescale 1ns / 1ps
// Front end: accepts event beats, classifies them and registers the command.
module midipair_front
  import midipair_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      evt_valid,
  output logic      evt_ready,
  input  evt_beat_t evt,
  output logic      cmd_valid,
  input  logic      cmd_ready,
  output cmd_t      cmd
);

  logic [1:0] kind;
  logic       keep;

  // A note-on with zero velocity counts as a note-off; the unused op is dropped.
  always_comb begin
    kind = KIND_POP;
    keep = 1'b1;
    case (evt.op)
      OP_NOTE_ON: begin
        kind = (evt.velocity != '0) ? KIND_PUSH : KIND_POP;
      end
      OP_NOTE_OFF: begin
        kind = KIND_POP;
      end
      OP_NEW_TRK: begin
        kind = KIND_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign evt_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (evt_ready) begin
      cmd_valid <= evt_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_ready && evt_valid) begin
      cmd.kind       <= kind;
      cmd.event_time <= evt.event_time;
      cmd.channel    <= evt.channel;
      cmd.key        <= evt.key;
      cmd.velocity   <= evt.velocity;
    end
  end

endmodule

// File: hw/rtl/midipair_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module midipair_queue
  import midipair_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (fill != FILL_W'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/midipair_back.sv
`timescale 1ns / 1ps
// Back end: per-key stack counts, stack memory and the result register.
module midipair_back
  import midipair_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd_in,
  output logic       note_valid,
  input  logic       note_ready,
  output note_beat_t note
);

  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int ST_DEPTH = NUM_KEYS * STACK_DEPTH;
  localparam int ST_AW    = $clog2(ST_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CNT   = 2'd1;
  localparam logic [1:0] ST_STORE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  cmd_t             cmd;

  logic [CNT_W-1:0] cnt_mem [NUM_KEYS];
  logic [CNT_W-1:0] cnt_rd;
  logic [NUM_KEYS-1:0] cnt_vld;
  logic [CNT_W-1:0] cnt_cur;
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wdata;

  pend_t            st_mem [ST_DEPTH];
  pend_t            pend_rd;
  logic             st_we;
  logic             st_re;
  logic [CNT_W-1:0] st_idx;
  logic [ST_AW-1:0] st_addr;

  logic             out_free;
  logic             out_load;
  note_beat_t       out_next;
  logic             clear_all;

  assign cmd_ready = (state == ST_IDLE);
  assign out_free  = !note_valid || note_ready;

  // A key whose valid bit is clear has no pending notes, whatever the memory holds.
  assign cnt_cur = cnt_vld[cmd.key] ? cnt_rd : '0;
  assign st_addr = ST_AW'(cmd.key) * ST_AW'(STACK_DEPTH) + ST_AW'(st_idx);

  always_comb begin
    state_next = state;
    cnt_we     = 1'b0;
    cnt_wdata  = cnt_cur;
    st_we      = 1'b0;
    st_re      = 1'b0;
    st_idx     = cnt_cur;
    out_load   = 1'b0;
    clear_all  = 1'b0;
    out_next   = '0;
    out_next.note_key = cmd.key;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_CNT;
        end
      end
      ST_CNT: begin
        case (cmd.kind)
          KIND_PUSH: begin
            if (cnt_cur >= CNT_W'(STACK_DEPTH)) begin
              out_next.status        = STAT_FULL;
              out_next.start_time    = cmd.event_time;
              out_next.note_channel  = cmd.channel;
              out_next.note_velocity = cmd.velocity;
              if (out_free) begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
              end
            end else begin
              st_we      = 1'b1;
              cnt_we     = 1'b1;
              cnt_wdata  = cnt_cur + 1'b1;
              state_next = ST_IDLE;
            end
          end
          KIND_POP: begin
            if (cnt_cur == '0) begin
              out_next.status   = STAT_UNMATCHED;
              out_next.end_time = cmd.event_time;
              if (out_free) begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
              end
            end else begin
              st_idx     = cnt_cur - 1'b1;
              st_re      = 1'b1;
              cnt_we     = 1'b1;
              cnt_wdata  = cnt_cur - 1'b1;
              state_next = ST_STORE;
            end
          end
          default: begin
            clear_all  = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_STORE: begin
        out_next.status        = STAT_COMPLETE;
        out_next.start_time    = pend_rd.start_time;
        out_next.end_time      = cmd.event_time;
        out_next.note_channel  = pend_rd.channel;
        out_next.note_velocity = pend_rd.velocity;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt_vld    <= '0;
      note_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clear_all) begin
        cnt_vld <= '0;
      end else if (cnt_we) begin
        cnt_vld[cmd.key] <= 1'b1;
      end
      if (out_load) begin
        note_valid <= 1'b1;
      end else if (note_ready) begin
        note_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd <= cmd_in;
    end
    if (out_load) begin
      note <= out_next;
    end
  end

  // Count memory: read when a command is taken, written once it is decided.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cnt_rd <= cnt_mem[cmd_in.key];
    end
    if (cnt_we) begin
      cnt_mem[cmd.key] <= cnt_wdata;
    end
  end

  // Stack memory: one access a cycle, read data registered.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_addr] <= '{start_time: cmd.event_time, channel: cmd.channel,
                           velocity: cmd.velocity};
    end
    if (st_re) begin
      pend_rd <= st_mem[st_addr];
    end
  end

endmodule

// File: hw/rtl/midi_note_on_off_pairing_core.sv
`timescale 1ns / 1ps
// Top level of the MIDI note-on / note-off pairing block.
// This block pairs MIDI note-ons with their note-offs. For each of the 128 keys it keeps
// a last-in-first-out stack of up to STACK_DEPTH pending note-ons; a note-off (or a
// note-on with zero velocity) pops the newest one of its key and emits a complete note
// carrying the start time, end time, key, and the channel and velocity of the note-on.
// Matching is by key alone. An off with nothing pending gives an unmatched status, a
// note-on onto a full stack is dropped and reported, and a new-track beat discards all
// pending notes at once without a result. Event beats are taken by a front stage and
// held in a four-entry command queue, so the input keeps flowing while a result waits
// on the output. The back end handles one command at a time through the per-key count
// memory and the stack memory, each with a registered read: a push, a rejected event or
// a new track passes through the idle and count states, and a matched note-off also
// through the store state, which takes the stack memory read. A rejected event or a
// matched note-off waits while a result on the output is not yet taken. No clearing
// pass is needed after reset: the pending counts are qualified by per-key valid bits
// that reset and new-track beats clear all at once.
module midi_note_on_off_pairing_core
  import midipair_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       evt_valid,
  output logic       evt_ready,
  input  evt_beat_t  evt,
  output logic       note_valid,
  input  logic       note_ready,
  output note_beat_t note
);

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // Front stage: classifies each event beat into a push, pop or clear command, or drops it.
  midipair_front u_front (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  // Command queue that decouples the front stage from the back end.
  midipair_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  // Back end: carries out each command against the per-key stacks.
  midipair_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd_in     (q_cmd),
    .note_valid (note_valid),
    .note_ready (note_ready),
    .note       (note)
  );

endmodule

// File: sim/midi_note_on_off_pairing_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MIDI note-on / note-off pairing core.
module midi_note_on_off_pairing_core_tb;
  import midipair_pkg::*;

  localparam int NOTE_STACK  = STACK_DEPTH_DEF;
  localparam int RAND_EVENTS = 1880;
  // Beats left in the queue below which both sides stop idling.
  localparam int CALM_TAIL   = 200;
  // Cycles with no beat on either side before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       evt_valid = 1'b0;
  logic       evt_ready;
  evt_beat_t  evt_beat = '0;
  logic       note_valid;
  logic       note_ready = 1'b0;
  note_beat_t note_beat;

  // Event beats waiting to be sent, and the notes the pairing logic should emit.
  evt_beat_t  event_q[$];
  note_beat_t notes_due[$];

  // Shadow of the per-key stacks of pending note-ons.
  int         key_depth [NUM_KEYS];
  pend_t      key_stack [NUM_KEYS][NOTE_STACK];

  logic       evt_fire = 1'b0;
  int         evt_gap = 0;
  int         note_gap = 0;
  int         quiet_cycles = 0;
  int         faults = 0;

  midi_note_on_off_pairing_core #(
    .STACK_DEPTH(NOTE_STACK)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt_beat),
    .note_valid(note_valid),
    .note_ready(note_ready),
    .note      (note_beat)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out what one accepted event beat does to the key stacks, and queues
  // the note it gives, if any. Matching is by key alone.
  function automatic void pair_event(evt_beat_t e);
    note_beat_t r;
    int         depth;
    r = '0;
    r.note_key = e.key;
    case (e.op)
      OP_NEW_TRK: begin
        foreach (key_depth[k]) key_depth[k] = 0;
      end
      OP_NOTE_ON, OP_NOTE_OFF: begin
        depth = key_depth[e.key];
        if (e.op == OP_NOTE_ON && e.velocity != '0) begin
          if (depth >= NOTE_STACK) begin
            // A full stack drops the note-on and reports it back.
            r.status        = STAT_FULL;
            r.start_time    = e.event_time;
            r.note_channel  = e.channel;
            r.note_velocity = e.velocity;
            notes_due.insert(notes_due.size(), r);
          end else begin
            key_stack[e.key][depth] = '{e.event_time, e.channel, e.velocity};
            key_depth[e.key] = depth + 1;
          end
        end else if (depth == 0) begin
          r.status   = STAT_UNMATCHED;
          r.end_time = e.event_time;
          notes_due.insert(notes_due.size(), r);
        end else begin
          // The newest pending note-on of the key is the one that closes.
          depth = depth - 1;
          key_depth[e.key] = depth;
          r.status        = STAT_COMPLETE;
          r.start_time    = key_stack[e.key][depth].start_time;
          r.end_time      = e.event_time;
          r.note_channel  = key_stack[e.key][depth].channel;
          r.note_velocity = key_stack[e.key][depth].velocity;
          notes_due.insert(notes_due.size(), r);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_fault(string what, logic [31:0] want, logic [31:0] got);
    faults++;
    if (faults <= 10) begin
      $display("%0t ns: note %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  task automatic check_note(note_beat_t got);
    note_beat_t want;
    if (notes_due.size() == 0) begin
      faults++;
      if (faults <= 10) begin
        $display("%0t ns: note beat with none expected: status %0d key %0d", $time,
                 got.status, got.note_key);
      end
    end else begin
      want = notes_due.pop_front();
      if (got.status !== want.status) begin
        note_fault("status", 32'(want.status), 32'(got.status));
      end
      if (got.start_time !== want.start_time) begin
        note_fault("start_time", want.start_time, got.start_time);
      end
      if (got.end_time !== want.end_time) note_fault("end_time", want.end_time, got.end_time);
      if (got.note_key !== want.note_key) begin
        note_fault("key", 32'(want.note_key), 32'(got.note_key));
      end
      if (got.note_channel !== want.note_channel) begin
        note_fault("channel", 32'(want.note_channel), 32'(got.note_channel));
      end
      if (got.note_velocity !== want.note_velocity) begin
        note_fault("velocity", 32'(want.note_velocity), 32'(got.note_velocity));
      end
    end
  endtask

  task automatic add_event(logic [1:0] op, logic [31:0] t, int ch, int k, int vel);
    evt_beat_t e;
    e.op         = op;
    e.event_time = t;
    e.channel    = ch[CHAN_W-1:0];
    e.key        = k[KEY_W-1:0];
    e.velocity   = vel[VEL_W-1:0];
    event_q.insert(event_q.size(), e);
  endtask

  // Monitor: both channels are sampled at the rising edge. The predictor runs on
  // every accepted event beat, and every accepted note beat is checked.
  always @(posedge clk) begin
    if (rst) begin
      evt_fire     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      evt_fire <= evt_valid && evt_ready;
      if (evt_valid && evt_ready) pair_event(evt_beat);
      if (note_valid && note_ready) check_note(note_beat);
      if ((evt_valid && evt_ready) || (note_valid && note_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Event driver: a beat is held until taken, then the next one is loaded,
  // sometimes after a burst of idle cycles.
  always @(negedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (!evt_valid || evt_fire) begin
      if (evt_gap > 0) begin
        evt_valid <= 1'b0;
        evt_gap   <= evt_gap - 1;
      end else if (event_q.size() > 0) begin
        evt_beat  <= event_q.pop_front();
        evt_valid <= 1'b1;
        if (event_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
          evt_gap <= $urandom_range(1, 15);
        end
      end else begin
        evt_valid <= 1'b0;
      end
    end
  end

  // Note receiver: ready drops for bursts of stall cycles until the tail of the run.
  always @(negedge clk) begin
    if (rst) begin
      note_ready <= 1'b0;
    end else if (note_gap > 0) begin
      note_ready <= 1'b0;
      note_gap   <= note_gap - 1;
    end else begin
      note_ready <= 1'b1;
      if (event_q.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
        note_gap <= $urandom_range(1, 15);
      end
    end
  end

  // Watchdog: the run is hung once nothing has moved on either side for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          pool [6];
    int          push_pct;
    int          pick;
    int          k;
    logic [31:0] t_now;

    foreach (key_depth[i]) key_depth[i] = 0;

    // Directed part: field extremes, every op, and each corner of the pairing.
    add_event(OP_NOTE_ON,  32'h0000_0000, 0,  0,   1);
    add_event(OP_NOTE_OFF, 32'hFFFF_FFFF, 15, 0,   127);  // completes the note on key 0
    add_event(OP_NOTE_OFF, 32'h0000_0010, 7,  0,   0);    // nothing left: unmatched
    add_event(OP_NOTE_ON,  32'hFFFF_FFFF, 15, 127, 127);
    add_event(OP_NOTE_ON,  32'h0000_0020, 0,  127, 0);    // zero velocity closes it
    add_event(OP_NOTE_ON,  32'h0000_0021, 0,  33,  0);    // zero velocity, none pending
    add_event(OP_NOTE_ON,  32'h0000_0100, 1,  60,  10);   // fill key 60 to the top
    add_event(OP_NOTE_ON,  32'h0000_0101, 2,  60,  20);
    add_event(OP_NOTE_ON,  32'h0000_0102, 3,  60,  30);
    add_event(OP_NOTE_ON,  32'h0000_0103, 4,  60,  40);
    add_event(OP_NOTE_ON,  32'h5555_AAAA, 9,  60,  50);   // stack full, dropped
    add_event(OP_NOTE_OFF, 32'h0000_0200, 3,  60,  0);    // last in, first out
    add_event(OP_NOTE_ON,  32'h0000_0201, 5,  60,  85);
    add_event(OP_UNUSED,   32'h0000_0202, 5,  60,  85);   // ignored outright
    add_event(OP_NOTE_OFF, 32'h0000_0203, 6,  60,  1);
    add_event(OP_NOTE_ON,  32'h0000_0300, 8,  61,  99);
    add_event(OP_NEW_TRK,  32'hFFFF_FFFF, 15, 127, 127);  // discards every pending note
    add_event(OP_NOTE_OFF, 32'h0000_0400, 0,  60,  0);
    add_event(OP_NOTE_OFF, 32'h0000_0401, 0,  61,  0);
    add_event(OP_UNUSED,   32'hFFFF_FFFF, 15, 127, 127);
    add_event(OP_NOTE_ON,  32'hAAAA_5555, 10, 42,  127);
    add_event(OP_NOTE_OFF, 32'h5555_AAAA, 5,  42,  64);

    // Random part: most events land on a small pool of keys so that stacks
    // fill, drain and overflow; the pool and the push bias change by segment.
    t_now = $urandom;
    push_pct = 50;
    for (int n = 0; n < RAND_EVENTS; n++) begin
      if (n % 120 == 0) begin
        foreach (pool[i]) pool[i] = $urandom_range(0, NUM_KEYS - 1);
        push_pct = $urandom_range(35, 65);
      end
      k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)]
                                        : $urandom_range(0, NUM_KEYS - 1);
      t_now = t_now + $urandom_range(0, 600);
      if ($urandom_range(0, 49) == 0) t_now = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        add_event(OP_NOTE_ON, t_now, $urandom_range(0, 15), k, $urandom_range(1, 127));
      end else if (pick < 89) begin
        add_event(OP_NOTE_OFF, t_now, $urandom_range(0, 15), k, $urandom_range(0, 127));
      end else if (pick < 96) begin
        add_event(OP_NOTE_ON, t_now, $urandom_range(0, 15), k, 0);
      end else if (pick < 98) begin
        add_event(OP_NEW_TRK, t_now, $urandom_range(0, 15), k, $urandom_range(0, 127));
      end else begin
        add_event(OP_UNUSED, t_now, $urandom_range(0, 15), k, $urandom_range(0, 127));
      end
    end

    // Synchronous reset, released away from the rising edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (event_q.size() != 0 || evt_valid) @(posedge clk);
    while (notes_due.size() != 0) @(posedge clk);
    // Let any stray note beat show itself before the verdict.
    repeat (DRAIN_WAIT) @(posedge clk);

    if (faults == 0 && notes_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
